FILE: rtl/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types for the bitmap identifier allocator: request and result beats,
// status codes and controller states.
// ----------------------------------------------------------------------------
package bia_pkg;

  // Width of an identifier on the ports; the usable capacity is clamped to 1 << ID_W.
  localparam int unsigned ID_W   = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NONE_FREE = 2'd1,
    STATUS_IGNORED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_FREE
  } ctrl_state_e;

  typedef struct packed {
    mode_e           mode;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_e         status;
  } rsp_t;

endpackage

FILE: rtl/bia_bitmap_mem.sv
// ----------------------------------------------------------------------------
// bia_bitmap_mem
// Bitmap word store: one write port, one read port with registered read data.
// Per-word valid bits stand in for the reset contents.
// ----------------------------------------------------------------------------
module bia_bitmap_mem #(
  parameter int unsigned WORD_COUNT = 8,
  parameter int unsigned ADDR_W     = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [31:0]       rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [31:0]       wr_data_i
);
  import bia_pkg::*;

  logic [WORD_W-1:0]     mem_q [WORD_COUNT];
  logic [WORD_COUNT-1:0] valid_q;
  logic [WORD_W-1:0]     rd_data_q;
  logic                  rd_valid_q;
  logic                  rd_first_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        rd_first_q <= (rd_addr_i == '0);
      end
    end
  end

  // A word never written reads as its reset value: word 0 holds the
  // reserved identifier 0, all other words are clear.
  assign rd_data_o = rd_valid_q ? rd_data_q : {{(WORD_W-1){1'b0}}, rd_first_q};

endmodule

FILE: rtl/bia_ctrl.sv
// ----------------------------------------------------------------------------
// bia_ctrl
// Allocation controller: scans bitmap words one per cycle for the lowest
// clear bit, or clears one bit on a free, and writes the word back.
// ----------------------------------------------------------------------------
module bia_ctrl #(
  parameter int unsigned WORD_COUNT = 8,
  parameter int unsigned ADDR_W     = 3,
  parameter int unsigned ID_LIMIT   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bia_pkg::req_t      req_i,
  output logic               done_o,
  output bia_pkg::rsp_t      result_o,
  output logic               rd_en_o,
  output logic [ADDR_W-1:0]  rd_addr_o,
  input  logic [31:0]        rd_data_i,
  output logic               wr_en_o,
  output logic [ADDR_W-1:0]  wr_addr_o,
  output logic [31:0]        wr_data_o
);
  import bia_pkg::*;

  localparam int unsigned TAIL = ID_LIMIT - (WORD_COUNT - 1) * WORD_W;
  // Bits of the last word at or above the capacity count as used.
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} << TAIL;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);

  ctrl_state_e       state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic [WORD_W-1:0] eff_word;
  logic              zero_found;
  logic [BIT_W-1:0]  zero_idx;
  logic              rid_ok;

  always_comb begin
    eff_word   = rd_data_i | ((ptr_q == LAST_WORD) ? LAST_MASK : '0);
    zero_found = 1'b0;
    zero_idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!eff_word[i]) begin
        zero_found = 1'b1;
        zero_idx   = BIT_W'(i);
      end
    end
  end

  assign rid_ok = (req_i.release_id != '0) &&
                  ({1'b0, req_i.release_id} < (ID_W + 1)'(ID_LIMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    bit_q <= bit_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    bit_d     = bit_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q;
    wr_en_o   = 1'b0;
    wr_addr_o = ptr_q;
    wr_data_o = rd_data_i;
    case (state_q)
      CTRL_IDLE: begin
        if (start) begin
          if (req_i.mode == MODE_ALLOC) begin
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            ptr_d     = '0;
            state_d   = CTRL_SCAN;
          end else if (rid_ok) begin
            rd_en_o   = 1'b1;
            rd_addr_o = ADDR_W'(req_i.release_id >> BIT_W);
            ptr_d     = ADDR_W'(req_i.release_id >> BIT_W);
            bit_d     = req_i.release_id[BIT_W-1:0];
            state_d   = CTRL_FREE;
          end else begin
            done_d           = 1'b1;
            rsp_d.granted_id = '0;
            rsp_d.status     = STATUS_IGNORED;
          end
        end
      end
      CTRL_SCAN: begin
        if (zero_found) begin
          wr_en_o          = 1'b1;
          wr_data_o        = rd_data_i | (WORD_W'(1) << zero_idx);
          done_d           = 1'b1;
          rsp_d.granted_id = ID_W'({ptr_q, zero_idx});
          rsp_d.status     = STATUS_OK;
          state_d          = CTRL_IDLE;
        end else if (ptr_q == LAST_WORD) begin
          done_d           = 1'b1;
          rsp_d.granted_id = '0;
          rsp_d.status     = STATUS_NONE_FREE;
          state_d          = CTRL_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = ADDR_W'(ptr_q + 1'b1);
          ptr_d     = ADDR_W'(ptr_q + 1'b1);
        end
      end
      CTRL_FREE: begin
        wr_en_o          = 1'b1;
        wr_data_o        = rd_data_i & ~(WORD_W'(1) << bit_q);
        done_d           = 1'b1;
        rsp_d.granted_id = '0;
        rsp_d.status     = STATUS_OK;
        state_d          = CTRL_IDLE;
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != CTRL_IDLE);
  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

FILE: rtl/bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free identifier allocator over a bitmap of used identifiers kept in
// 32-bit words of a small synchronous memory.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Beat taken when
//   --------  ---------------------------  ---------------------------------
//   request   start, busy, req_i           start high and busy low at clk_i
//   result    done_o, result_o             done_o high, for that one cycle
//
// A free of an identifier in range reads its word, then clears the bit and
// writes the word back. An allocate scans the bitmap, reading one bitmap
// word per cycle from the single read port until a word with a clear bit
// turns up or the last word has been read. An ignored free does not raise
// busy. The result shows in the cycle after the last edge of its work,
// which is also the first cycle with busy low. After reset the bitmap reads
// as empty apart from identifier 0; no clearing pass is needed. The receiver
// cannot stall results.
//
module bitmap_id_allocator #(
  parameter int unsigned ID_COUNT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bia_pkg::req_t req_i,
  output logic          done_o,
  output bia_pkg::rsp_t result_o
);
  import bia_pkg::*;

  // Identifiers are 8 bits wide, so capacity is clamped to 256.
  localparam int unsigned ID_LIMIT   = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int unsigned WORD_COUNT = (ID_LIMIT + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  // Items are handled one at a time and each write lands before the next
  // read is issued, so the read-modify-write needs no forwarding path.
  bia_ctrl #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (ADDR_W),
    .ID_LIMIT   (ID_LIMIT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .result_o  (result_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  bia_bitmap_mem #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

`ifndef NO_ASSERTIONS
  // A result beat is only presented once the work on its item is over.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

  // Every item that raised busy produces its result beat as busy falls.
  a_fall_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result beat");

  // A failed or ignored request hands out identifier 0.
  a_zero_id_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STATUS_NONE_FREE ||
                result_o.status == STATUS_IGNORED)) |-> (result_o.granted_id == '0))
    else $error("nonzero identifier on a failed request");

  // Freeing the reserved identifier is rejected in the next cycle.
  a_free_zero_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.mode == MODE_FREE && req_i.release_id == '0) |=>
      (done_o && result_o.status == STATUS_IGNORED))
    else $error("free of identifier 0 not ignored");
`endif

endmodule
